[rtl/mfb_pkg.sv]
package mfb_pkg;

  localparam int ScreenWidth  = 64;
  localparam int ScreenHeight = 32;
  localparam int TileRows     = 64;
  localparam int TileCols     = 64;

  localparam int FramePages = (ScreenHeight + 7) / 8;
  localparam int FrameBytes = ScreenWidth * FramePages;
  localparam int TileBytes  = TileCols * ((TileRows + 7) / 8);
  localparam int FrameAw    = $clog2(FrameBytes);
  localparam int TileAw     = $clog2(TileBytes);

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_CLEAR = 3'd1;
  localparam logic [2:0] MODE_SET   = 3'd2;
  localparam logic [2:0] MODE_CLR   = 3'd3;
  localparam logic [2:0] MODE_BLIT  = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  // Controller -> datapath commands.
  typedef struct packed {
    logic latch;       // capture request fields
    logic tile_wr;     // write tile byte
    logic frame_rd;    // read frame byte at current address
    logic frame_wr;    // write modified byte
    logic sweep_inc;   // advance clear sweep counter
    logic sweep_wr;    // write zero at sweep counter
    logic blit_rd;     // read tile and frame for current blit pixel
    logic blit_step;   // advance blit counters
    logic take_read;   // load result register from frame read data
  } mfb_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic sweep_last;
    logic blit_empty;
    logic blit_last;
  } mfb_status_t;

endpackage

[rtl/mfb_datapath.sv]
module mfb_datapath import mfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mfb_cmd_t    cmd,
  output mfb_status_t status,
  input  logic [2:0]  mode,
  input  logic [8:0]  address,
  input  logic [7:0]  data,
  input  logic [5:0]  src_x,
  input  logic [5:0]  src_y,
  input  logic [6:0]  width,
  input  logic [6:0]  height,
  input  logic signed [7:0] dst_x,
  input  logic signed [7:0] dst_y,
  output logic [7:0]  result
);

  logic [7:0] frame_mem [FrameBytes];
  logic [7:0] tile_mem [TileBytes];

  logic [2:0] r_mode;
  logic [8:0] r_addr;
  logic [7:0] r_data;
  logic [5:0] r_sx, r_sy;
  logic [6:0] r_w, r_h;
  logic signed [7:0] r_dx, r_dy;
  logic [6:0] col, row;

  logic [7:0] frame_q, tile_q;
  logic [FrameAw-1:0] wr_idx;
  logic [2:0] wr_bit;
  logic [2:0] wr_sbit;
  logic wr_on, wr_vis;
  logic [FrameAw-1:0] sweep;

  // Current target pixel (pixel ops use col=row=0).
  logic signed [9:0] tx, ty;
  logic vis;
  logic [FrameAw-1:0] pix_idx;
  logic [2:0] pix_bit;
  logic [7:0] sxs, sys;
  logic [TileAw-1:0] tile_idx;

  always_comb begin
    tx  = 10'(r_dx) + $signed({3'b0, col});
    ty  = 10'(r_dy) + $signed({3'b0, row});
    vis = (tx >= 0) && (tx < ScreenWidth) && (ty >= 0) && (ty < ScreenHeight);
    pix_idx = FrameAw'(tx[7:0] + ((ty[7:0] >> 3) * ScreenWidth));
    pix_bit = ty[2:0];
    sxs = 8'(r_sx) + 8'(col);
    sys = 8'(r_sy) + 8'(row);
    tile_idx = TileAw'(32'(sxs) + 32'(sys >> 3) * TileCols);
  end

  assign status.sweep_last = (sweep == FrameAw'(FrameBytes - 1));
  assign status.blit_empty = (r_w == 7'd0) || (r_h == 7'd0);
  assign status.blit_last  = (col == r_w - 7'd1) && (row == r_h - 7'd1);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_mode <= mode; r_addr <= address; r_data <= data;
      r_sx <= src_x; r_sy <= src_y; r_w <= width; r_h <= height;
      r_dx <= dst_x; r_dy <= dst_y;
    end
    if (rst || cmd.latch) begin
      col <= '0; row <= '0; sweep <= '0;
    end else begin
      if (cmd.sweep_inc) sweep <= sweep + 1'b1;
      if (cmd.blit_step) begin
        if (col == r_w - 7'd1) begin
          col <= '0; row <= row + 7'd1;
        end else begin
          col <= col + 7'd1;
        end
      end
    end
  end

  // Tile store.
  always_ff @(posedge clk) begin
    if (cmd.tile_wr) tile_mem[r_addr[TileAw-1:0]] <= r_data;
    tile_q <= tile_mem[tile_idx];
  end

  // Frame store: one read port, one write port.
  logic [FrameAw-1:0] rd_idx;
  always_comb begin
    if (r_mode == MODE_READ) rd_idx = r_addr[FrameAw-1:0];
    else                     rd_idx = pix_idx;
  end

  always_ff @(posedge clk) begin
    frame_q <= frame_mem[rd_idx];
    if (cmd.frame_rd || cmd.blit_rd) begin
      wr_idx <= pix_idx; wr_bit <= pix_bit; wr_vis <= vis;
      wr_sbit <= sys[2:0];
      wr_on  <= (r_mode == MODE_SET);
    end
    if (cmd.sweep_wr)
      frame_mem[sweep] <= 8'd0;
    else if (cmd.frame_wr && wr_vis) begin
      if (r_mode == MODE_BLIT ? tile_q[wr_sbit] : wr_on)
        frame_mem[wr_idx] <= frame_q | (8'd1 << wr_bit);
      else
        frame_mem[wr_idx] <= frame_q & ~(8'd1 << wr_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch)          result <= '0;
    else if (cmd.take_read) result <= frame_q;
  end

endmodule

[rtl/mfb_ctrl.sv]
module mfb_ctrl import mfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  output logic        out_valid,
  input  logic        out_ready,
  input  mfb_status_t status,
  output mfb_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DEC   = 8'b00000010,
    S_SWEEP = 8'b00000100,
    S_PRD   = 8'b00001000,
    S_PWR   = 8'b00010000,
    S_BWR   = 8'b00100000,
    S_RDW   = 8'b01000000,
    S_INIT  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [2:0] r_mode;
  logic out_valid_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_valid_next = out_valid && !out_ready;
    cmd.latch = in_valid && in_ready;
    case (state)
      S_IDLE:  if (cmd.latch) state_next = S_DEC;
      S_INIT: begin
        // zero the frame after reset, no result
        cmd.sweep_wr = 1'b1; cmd.sweep_inc = 1'b1;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_DEC: begin
        case (r_mode)
          MODE_LOAD: begin
            cmd.tile_wr = 1'b1; out_valid_next = 1'b1; state_next = S_IDLE;
          end
          MODE_CLEAR: state_next = S_SWEEP;
          MODE_SET, MODE_CLR: begin
            cmd.frame_rd = 1'b1; state_next = S_PWR;
          end
          MODE_BLIT: begin
            if (status.blit_empty) begin
              out_valid_next = 1'b1; state_next = S_IDLE;
            end else begin
              cmd.blit_rd = 1'b1; state_next = S_BWR;
            end
          end
          MODE_READ: state_next = S_RDW;
          default: begin
            out_valid_next = 1'b1; state_next = S_IDLE;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1; cmd.sweep_inc = 1'b1;
        if (status.sweep_last) begin
          out_valid_next = 1'b1; state_next = S_IDLE;
        end
      end
      S_PWR: begin
        cmd.frame_wr = 1'b1; out_valid_next = 1'b1; state_next = S_IDLE;
      end
      S_BWR: begin
        cmd.frame_wr = 1'b1;
        if (status.blit_last) begin
          out_valid_next = 1'b1; state_next = S_IDLE;
        end else begin
          cmd.blit_step = 1'b1; state_next = S_PRD;
        end
      end
      S_PRD: begin
        cmd.blit_rd = 1'b1; state_next = S_BWR;
      end
      S_RDW: begin
        cmd.take_read = 1'b1; out_valid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
    if (cmd.latch) r_mode <= mode;
  end

endmodule

[rtl/mono_framebuffer_blitter.sv]
// Monochrome framebuffer blitter: 64x32 one-bit frame, 512-byte tile store,
// both in page layout (byte = x + (y/8)*64, bit = y%8).
// Input channel (in_valid/in_ready) carries one request: mode plus fields.
// Output channel (out_valid/out_ready) returns one read_data per request;
// it is the frame byte for a read request and zero otherwise.
// Request handling, accept to out_valid: a tile byte load writes in decode;
// a byte read captures the frame byte after decode; set/clear pixel reads
// then writes the byte; clear screen zeroes one frame byte per cycle; blit
// reads then writes per pixel through the single frame store port pair,
// and an empty rectangle returns straight from decode.
// One request is in flight at a time; in_ready returns once the result has
// been taken. A stalled receiver holds out_valid and read_data steady and
// the block takes no new request meanwhile.
// Reset starts a pass that zeroes the frame store, one byte per cycle;
// in_ready stays low until it is done.
// The tile store is undefined until loaded.
module mono_framebuffer_blitter import mfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [8:0]  address,
  input  logic [7:0]  data,
  input  logic [5:0]  src_x,
  input  logic [5:0]  src_y,
  input  logic [6:0]  width,
  input  logic [6:0]  height,
  input  logic signed [7:0] dst_x,
  input  logic signed [7:0] dst_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data
);

  mfb_cmd_t    cmd;
  mfb_status_t status;

  mfb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .mode,
    .out_valid, .out_ready, .status, .cmd
  );

  mfb_datapath u_dp (
    .clk, .rst, .cmd, .status, .mode, .address, .data,
    .src_x, .src_y, .width, .height, .dst_x, .dst_y,
    .result(read_data)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(read_data))
    else $error("result changed under stall");
  a_accept_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("early result");
`endif

endmodule

[test/fb_scoreboard.sv]
`timescale 1ns / 100ps

// Watches both channels, tracks frame and tile contents, and checks every
// returned read_data against the predicted byte.
module fb_scoreboard import mfb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        mode,
  input  logic [8:0]        address,
  input  logic [7:0]        data,
  input  logic [5:0]        src_x,
  input  logic [5:0]        src_y,
  input  logic [6:0]        width,
  input  logic [6:0]        height,
  input  logic signed [7:0] dst_x,
  input  logic signed [7:0] dst_y,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        read_data,
  output int                fail_count,
  output int                pending
);

  logic [7:0] frame_mem [FrameBytes];
  logic [7:0] tile_mem [TileBytes];
  logic [7:0] expected_bytes [$];
  int         errors;

  function automatic void draw_pixel(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= ScreenWidth || y < 0 || y >= ScreenHeight) return;
    idx = x + (y / 8) * ScreenWidth;
    frame_mem[idx][y % 8] = on;
  endfunction

  function automatic bit tile_bit(int x, int y);
    int idx;
    idx = (x + (y / 8) * TileCols) % TileBytes;
    return tile_mem[idx][y % 8];
  endfunction

  // Applies one request to the tracked stores, returns the byte it yields.
  function automatic logic [7:0] apply_request();
    int dx, dy;
    logic [7:0] rd;
    dx = int'(dst_x);
    dy = int'(dst_y);
    rd = '0;
    case (mode)
      MODE_LOAD: tile_mem[address % TileBytes] = data;
      MODE_CLEAR: foreach (frame_mem[i]) frame_mem[i] = '0;
      MODE_SET: draw_pixel(dx, dy, 1'b1);
      MODE_CLR: draw_pixel(dx, dy, 1'b0);
      MODE_BLIT: begin
        for (int r = 0; r < int'(height); r++)
          for (int c = 0; c < int'(width); c++)
            if (dy + r >= 0 && dy + r < ScreenHeight && dx + c >= 0 && dx + c < ScreenWidth)
              draw_pixel(dx + c, dy + r, tile_bit(int'(src_x) + c, int'(src_y) + r));
      end
      MODE_READ: rd = frame_mem[address % FrameBytes];
      default: ;
    endcase
    return rd;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      foreach (frame_mem[i]) frame_mem[i] = '0;
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result read_data=%h", read_data);
        end else begin
          want = expected_bytes.pop_front();
          if (read_data !== want) begin
            errors++;
            if (errors <= 10)
              $display("read_data mismatch: expected %h got %h", want, read_data);
          end
        end
      end
      if (in_valid && in_ready) expected_bytes.push_back(apply_request());
    end
    fail_count <= errors;
    pending    <= expected_bytes.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mfb_pkg::*;

  // Modes the block leaves unused: they must change nothing and return zero.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int CycleLimit = 4_000_000;
  localparam int TotalRequests = 290;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        mode = '0;
  logic [8:0]        address = '0;
  logic [7:0]        data = '0;
  logic [5:0]        src_x = '0;
  logic [5:0]        src_y = '0;
  logic [6:0]        width = '0;
  logic [6:0]        height = '0;
  logic signed [7:0] dst_x = '0;
  logic signed [7:0] dst_y = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        read_data;
  int                fail_count;
  int                pending;

  int  cycle_count = 0;
  int  burst_left = 4;
  int  sent = 0;
  int  blits_sent = 0;
  int  large_blits = 0;
  bit  tile_loaded [TileBytes];  // never blit from an unloaded tile byte

  always #5 clk = ~clk;

  mono_framebuffer_blitter u_top (.*);

  fb_scoreboard u_scoreboard (.*);

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall pattern rotates through four styles: one style never
  // stalls, others stall randomly, heavily or periodically.
  always @(posedge clk) begin
    case ((cycle_count >> 7) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom % 4) != 0;
      2: out_ready <= ($urandom % 3) == 0;
      default: out_ready <= cycle_count[2];
    endcase
  end

  // Drive one request and hold it until accepted. Sender works in bursts;
  // after each burst valid drops for a random gap.
  task automatic issue(logic [2:0] m, logic [8:0] a, logic [7:0] d,
                       logic [5:0] sx, logic [5:0] sy, logic [6:0] w, logic [6:0] h,
                       logic [7:0] dx, logic [7:0] dy);
    in_valid <= 1'b1;
    mode     <= m;
    address  <= a;
    data     <= d;
    src_x    <= sx;
    src_y    <= sy;
    width    <= w;
    height   <= h;
    dst_x    <= dx;
    dst_y    <= dy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (m == MODE_LOAD) tile_loaded[a] = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Non-blit request with every unused field randomized.
  task automatic simple(logic [2:0] m, logic [8:0] a, logic [7:0] d,
                        logic [7:0] dx, logic [7:0] dy);
    issue(m, a, d, $urandom, $urandom, $urandom, $urandom, dx, dy);
  endtask

  // Number of distinct tile bytes a blit source still needs loaded.
  function automatic int missing_loads(logic [5:0] sx, logic [5:0] sy,
                                       logic [6:0] w, logic [6:0] h);
    bit seen [TileBytes];
    int idx;
    int cnt;
    cnt = 0;
    for (int r = 0; r < int'(h); r++)
      for (int c = 0; c < int'(w); c++) begin
        idx = (int'(sx) + c + ((int'(sy) + r) / 8) * TileCols) % TileBytes;
        if (!tile_loaded[idx] && !seen[idx]) begin
          seen[idx] = 1'b1;
          cnt++;
        end
      end
    return cnt;
  endfunction

  // Blit; first loads any tile byte in the source rectangle not yet loaded.
  task automatic blit(logic [5:0] sx, logic [5:0] sy, logic [6:0] w, logic [6:0] h,
                      logic [7:0] dx, logic [7:0] dy);
    int idx;
    for (int r = 0; r < int'(h); r++)
      for (int c = 0; c < int'(w); c++) begin
        idx = (int'(sx) + c + ((int'(sy) + r) / 8) * TileCols) % TileBytes;
        if (!tile_loaded[idx]) simple(MODE_LOAD, idx[8:0], $urandom, $urandom, $urandom);
      end
    issue(MODE_BLIT, $urandom, $urandom, sx, sy, w, h, dx, dy);
    blits_sent++;
    if (w >= 64 || h >= 64) large_blits++;
  endtask

  function automatic logic [7:0] near_coord(int hi);
    return ($urandom % 5 == 0) ? 8'($urandom) : 8'($urandom_range(0, hi + 16) - 8);
  endfunction

  initial begin
    int pick;
    logic [6:0] w, h;
    logic [5:0] bsx, bsy;
    bit held;
    held = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Frame store comes out of reset all zero.
    simple(MODE_READ, 9'd0, '0, '0, '0);
    simple(MODE_READ, 9'd200, '0, '0, '0);
    simple(MODE_CLEAR, '0, '0, '0, '0);
    simple(MODE_LOAD, 9'd0, 8'hFF, '0, '0);
    simple(MODE_LOAD, 9'd511, 8'hA5, '0, '0);
    // Pixel corners plus off-screen destinations on every side.
    simple(MODE_SET, '0, '0, 8'sd0, 8'sd0);
    simple(MODE_SET, '0, '0, 8'sd63, 8'sd31);
    simple(MODE_SET, '0, '0, 8'sd64, 8'sd0);
    simple(MODE_SET, '0, '0, -8'sd1, 8'sd5);
    simple(MODE_SET, '0, '0, -8'sd128, 8'sd127);
    simple(MODE_SET, '0, '0, 8'sd127, -8'sd128);
    simple(MODE_READ, 9'd0, '0, '0, '0);
    simple(MODE_READ, 9'd255, '0, '0, '0);
    simple(MODE_CLR, '0, '0, 8'sd0, 8'sd0);
    simple(MODE_READ, 9'd256, '0, '0, '0);  // wraps to byte 0
    // Empty rectangles, then clipped blits and a source that wraps the store.
    blit(6'd0, 6'd0, 7'd0, 7'd8, 8'sd0, 8'sd0);
    blit(6'd0, 6'd0, 7'd8, 7'd0, 8'sd0, 8'sd0);
    blit(6'd0, 6'd0, 7'd6, 7'd6, -8'sd3, -8'sd2);
    blit(6'd60, 6'd60, 7'd10, 7'd6, 8'sd60, 8'sd28);
    simple(MODE_SPARE_A, 9'h1FF, 8'hFF, 8'sd1, 8'sd1);
    simple(MODE_SPARE_B, 9'h1FF, 8'hFF, 8'sd2, 8'sd2);
    simple(MODE_READ, 9'd511, '0, '0, '0);
    simple(MODE_READ, 9'd60, '0, '0, '0);

    while (sent < TotalRequests) begin
      // Hold-off once midway: let every result drain.
      if (!held && sent >= TotalRequests / 2) begin
        held = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      pick = $urandom % 100;
      if (pick < 25) simple(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 40) simple(MODE_SET, $urandom, $urandom, near_coord(63), near_coord(31));
      else if (pick < 50) simple(MODE_CLR, $urandom, $urandom, near_coord(63), near_coord(31));
      else if (pick < 70) begin
        w = ($urandom % 40 == 0) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(0, 16));
        h = ($urandom % 40 == 0) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(0, 16));
        bsx = 6'($urandom);
        bsy = 6'($urandom);
        // Keep the tile loads a blit pulls in within the request budget.
        if (sent + missing_loads(bsx, bsy, w, h) < TotalRequests)
          blit(bsx, bsy, w, h, near_coord(63), near_coord(31));
        else
          simple(MODE_READ, $urandom, $urandom, $urandom, $urandom);
      end
      else if (pick < 94) simple(MODE_READ, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 97) simple(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
      else simple(($urandom % 2) ? MODE_SPARE_A : MODE_SPARE_B, $urandom, $urandom,
                  $urandom, $urandom);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d requests, %0d of them blits (%0d with a side of 64 or more).",
             sent, blits_sent, large_blits);
    $display("Covered pixel set/clear with clipping, tile wrap, read wrap and spare modes.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
